[hw/rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and helpers of the JSON string unescape core.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int QueueDepth = 2;

    localparam int JobBytes = 4;

    localparam logic [7:0] ChBsl   = 8'h5C;
    localparam logic [7:0] ChN     = 8'h6E;
    localparam logic [7:0] ChR     = 8'h72;
    localparam logic [7:0] ChT     = 8'h74;
    localparam logic [7:0] ChB     = 8'h62;
    localparam logic [7:0] ChF     = 8'h66;
    localparam logic [7:0] ChU     = 8'h75;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChTab   = 8'h09;

    localparam logic [7:0]  Utf8Lead2 = 8'hC0;
    localparam logic [7:0]  Utf8Lead3 = 8'hE0;
    localparam logic [7:0]  Utf8Cont  = 8'h80;
    localparam logic [7:0]  Utf8Mask  = 8'h3F;
    localparam logic [15:0] Utf8Lim1  = 16'h0080;
    localparam logic [15:0] Utf8Lim2  = 16'h0800;

    typedef enum logic [2:0] {
        MODE_TEXT = 3'b001,
        MODE_ESC  = 3'b010,
        MODE_HEX  = 3'b100
    } t_mode;

    // one classified input beat: up to four output bytes
    typedef struct packed {
        logic [JobBytes-1:0][7:0] bytes;
        logic [2:0]               beats;
        logic                     bvalid;
        logic                     last;
    } t_job;

    // {ok, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[hw/rtl/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw bytes, tracks escape state and turns each byte into a job
// of zero to four output bytes for the back end.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_last_char,
    input  logic        i_full,
    output logic        o_push,
    output jsu_pkg::t_job o_job
);

    jsu_pkg::t_mode   r_mode, n_mode;
    logic [1:0]       r_hex_cnt, n_hex_cnt;
    logic [2:0][7:0]  r_held;
    logic             hold_we;
    logic [4:0]       hv;
    logic             ok;
    logic [15:0]      cp;
    logic [4:0]       h0, h1, h2;
    logic             text_esc;
    logic             take;
    jsu_pkg::t_job    job;

    assign take     = i_valid && o_ready;
    assign o_ready  = !i_full;
    assign hv       = jsu_pkg::hex_val(i_char_in);
    assign ok       = hv[4];
    assign text_esc = (i_char_in == jsu_pkg::ChBsl) && !i_last_char;

    assign h0 = jsu_pkg::hex_val(r_held[0]);
    assign h1 = jsu_pkg::hex_val(r_held[1]);
    assign h2 = jsu_pkg::hex_val(r_held[2]);
    assign cp = {h0[3:0], h1[3:0], h2[3:0], hv[3:0]};

    always_comb begin
        n_mode     = r_mode;
        n_hex_cnt  = r_hex_cnt;
        hold_we    = 1'b0;
        job        = '0;
        job.bvalid = 1'b1;
        job.last   = i_last_char;
        unique case (r_mode)
            jsu_pkg::MODE_ESC: begin
                n_mode = jsu_pkg::MODE_TEXT;
                job.beats = 3'd1;
                unique case (i_char_in)
                    jsu_pkg::ChN: job.bytes[0] = jsu_pkg::ChLf;
                    jsu_pkg::ChR: job.bytes[0] = jsu_pkg::ChCr;
                    jsu_pkg::ChT: job.bytes[0] = jsu_pkg::ChTab;
                    jsu_pkg::ChB, jsu_pkg::ChF: job.beats = 3'd0;
                    jsu_pkg::ChU: begin
                        job.beats = 3'd0;
                        n_mode    = jsu_pkg::MODE_HEX;
                        n_hex_cnt = 2'd0;
                    end
                    default: job.bytes[0] = i_char_in;
                endcase
            end
            jsu_pkg::MODE_HEX: begin
                if (ok && r_hex_cnt == 2'd3) begin
                    n_mode    = jsu_pkg::MODE_TEXT;
                    n_hex_cnt = 2'd0;
                    if (cp < jsu_pkg::Utf8Lim1) begin
                        job.beats    = 3'd1;
                        job.bytes[0] = cp[7:0];
                    end else if (cp < jsu_pkg::Utf8Lim2) begin
                        job.beats    = 3'd2;
                        job.bytes[0] = jsu_pkg::Utf8Lead2 | {3'd0, cp[10:6]};
                        job.bytes[1] = jsu_pkg::Utf8Cont | ({2'd0, cp[5:0]} & jsu_pkg::Utf8Mask);
                    end else begin
                        job.beats    = 3'd3;
                        job.bytes[0] = jsu_pkg::Utf8Lead3 | {4'd0, cp[15:12]};
                        job.bytes[1] = jsu_pkg::Utf8Cont | ({2'd0, cp[11:6]} & jsu_pkg::Utf8Mask);
                        job.bytes[2] = jsu_pkg::Utf8Cont | ({2'd0, cp[5:0]} & jsu_pkg::Utf8Mask);
                    end
                end else if (ok && !i_last_char) begin
                    hold_we   = 1'b1;
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end else begin
                    // abandoned \u: replay held digits, then the byte as text unless it opens an escape
                    n_mode    = text_esc ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_TEXT;
                    n_hex_cnt = 2'd0;
                    for (int k = 0; k < 3; k++) begin
                        job.bytes[k] = (2'(k) < r_hex_cnt) ? r_held[k] : i_char_in;
                    end
                    job.bytes[3] = i_char_in;
                    job.beats    = {1'b0, r_hex_cnt} + {2'd0, !text_esc};
                end
            end
            default: begin
                n_mode       = text_esc ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_TEXT;
                job.bytes[0] = i_char_in;
                job.beats    = {2'd0, !text_esc};
            end
        endcase
        if (i_last_char) begin
            n_mode    = jsu_pkg::MODE_TEXT;
            n_hex_cnt = 2'd0;
            if (job.beats == 3'd0) begin
                job.beats    = 3'd1;
                job.bvalid   = 1'b0;
                job.bytes[0] = 8'd0;
            end
        end
    end

    assign o_job  = job;
    assign o_push = take && (job.beats != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_TEXT;
            r_hex_cnt <= 2'd0;
        end else if (take) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && hold_we) begin
            r_held[r_hex_cnt] <= i_char_in;
        end
    end

    a_cnt_in_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hex_cnt != 2'd0) |-> (r_mode == jsu_pkg::MODE_HEX))
        else $error("hex digits held outside \\u");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.beats != 3'd0 && o_job.beats <= 3'd4))
        else $error("job beat count out of range");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_last_char) |=> (r_mode == jsu_pkg::MODE_TEXT && r_hex_cnt == 2'd0))
        else $error("state not cleared at string end");

endmodule

[hw/rtl/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Short FIFO of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    input  logic          i_pop,
    output jsu_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_job  r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[hw/rtl/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Walks the head job one byte per beat into the output register.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsu_pkg::t_job i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte_out,
    output logic          o_byte_valid,
    output logic          o_run_last,
    output logic          o_string_end
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bvalid, r_run_last, r_str_end;
    logic       load;
    logic       last_beat;

    assign load      = !i_empty && (!r_valid || i_ready);
    assign last_beat = ({1'b0, r_idx} == (i_head.beats - 3'd1));
    assign o_pop     = load && last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_beat ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= i_head.bytes[r_idx];
            r_bvalid   <= i_head.bvalid;
            r_run_last <= last_beat;
            r_str_end  <= last_beat && i_head.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte_out   = r_byte;
    assign o_byte_valid = r_bvalid;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_str_end;

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_end) |-> o_run_last)
        else $error("string end not on last beat of run");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_string_end && o_byte_out == 8'd0))
        else $error("bare marker not at string end");

endmodule

[hw/rtl/json_string_unescape_core.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Streaming JSON string unescaper with UTF-8 output for \u escapes.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-----------------------------------
//   in      | in  | i_valid / o_ready   | i_char_in, i_last_char
//   out     | out | o_valid / i_ready   | o_byte_out, o_byte_valid,
//           |     |                     | o_run_last, o_string_end
//
// One input beat per cycle while the job FIFO has room; each beat yields
// 0 to 4 output beats, drained one per cycle by the back end while i_ready is
// high. An accepted beat's job enters the job FIFO and then the output register
// (raising o_valid) if the register is free. o_ready drops only when the
// QUEUE_DEPTH job FIFO is full: the back end drains a multi-byte job or i_ready
// is held low. Synchronous active-low reset clears control state.
// ----------------------------------------------------------------------------
module json_string_unescape_core #(
    parameter int QUEUE_DEPTH = jsu_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_string_end
);

    jsu_pkg::t_job push_job, head_job;
    logic          push, pop, full, empty;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_byte_out   (o_byte_out),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

endmodule
